FILE: rtl/button_long_double_press_detector_top_assert.svh
// Assertion macros for the button long/double press detector.
`ifndef BUTTON_LONG_DOUBLE_PRESS_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_LONG_DOUBLE_PRESS_DETECTOR_TOP_ASSERT_SVH

// Clocked check, disabled during reset.
`define BLDPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked implication check, disabled during reset.
`define BLDPD_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

`endif

FILE: rtl/bldpd_pkg.sv
// Types and constants of the button long/double press detector.
package bldpd_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned INDEX_W = 2;
    localparam int unsigned COUNT_W = 2;

    localparam logic [INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_WINDOW   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_LONG     = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd500;
    localparam logic [CFG_W-1:0] LONG_RESET     = 16'd5000;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              button_level;
    } bldpd_in_t;

    typedef struct packed {
        logic hard_reset_request;
        logic soft_reset_request;
    } bldpd_out_t;

endpackage

FILE: rtl/button_long_double_press_detector_top.sv
// Top level of the button long/double press detector.
//
// Input channel (s_valid, s_ready, s_data): one button edge item with a
// wrapping millisecond timestamp and the sampled level (0 = pressed).
// Result channel (m_valid, m_ready, m_data): one item per input item with
// hard_reset_request (double press) and soft_reset_request (long press end).
// Config port: cfg_we writes cfg_wdata into the register cfg_addr selects
// (0 debounce, 1 double press window, 2 long press); other indexes are ignored.
// An item is captured in the input register, evaluated combinationally
// against the press state and placed in the result register, which drives
// m_valid; throughput one item per cycle while m_ready is high. Both
// registers hold while m_ready is low; s_ready drops once both are full
// and m_ready is low. The press state updates as an item moves into
// the result register, so the next item sees it at once.
// Reset (aresetn low, synchronous) empties both stages, clears the press
// state and timestamps to zero and loads the register defaults 50/500/5000.
module button_long_double_press_detector_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bldpd_pkg::bldpd_in_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bldpd_pkg::bldpd_out_t             m_data,
    input  logic                              cfg_we,
    input  logic [bldpd_pkg::INDEX_W-1:0]     cfg_addr,
    input  logic [bldpd_pkg::CFG_W-1:0]       cfg_wdata
);
    import bldpd_pkg::*;

    logic [CFG_W-1:0]   debounce_reg;
    logic [CFG_W-1:0]   window_reg;
    logic [CFG_W-1:0]   long_reg;

    logic               in_valid_reg;
    bldpd_in_t          in_data_reg;
    logic               out_valid_reg;
    bldpd_out_t         out_data_reg;

    logic [TIME_W-1:0]  last_accepted_reg;
    logic [TIME_W-1:0]  press_start_reg;
    logic [TIME_W-1:0]  last_press_reg;
    logic [COUNT_W-1:0] press_count_reg;

    logic [TIME_W-1:0]  last_accepted_next;
    logic [TIME_W-1:0]  press_start_next;
    logic [TIME_W-1:0]  last_press_next;
    logic [COUNT_W-1:0] press_count_next;
    bldpd_out_t         out_data_next;

    logic               advance;
    logic               step;
    logic [TIME_W-1:0]  since_accepted;
    logic [TIME_W-1:0]  since_start;
    logic [TIME_W-1:0]  since_press;
    logic               within_window;
    logic [COUNT_W-1:0] count_tmp;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            window_reg   <= WINDOW_RESET;
            long_reg     <= LONG_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                REG_WINDOW:   window_reg   <= cfg_wdata;
                REG_LONG:     long_reg     <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        since_accepted = in_data_reg.time_ms - last_accepted_reg;
        since_start    = in_data_reg.time_ms - press_start_reg;
        since_press    = in_data_reg.time_ms - last_press_reg;
        within_window  = since_press <= {{(TIME_W-CFG_W){1'b0}}, window_reg};

        last_accepted_next = last_accepted_reg;
        press_start_next   = press_start_reg;
        last_press_next    = last_press_reg;
        press_count_next   = press_count_reg;
        count_tmp          = press_count_reg;
        out_data_next      = '0;

        if (since_accepted >= {{(TIME_W-CFG_W){1'b0}}, debounce_reg}) begin
            last_accepted_next = in_data_reg.time_ms;
            if (!in_data_reg.button_level) begin
                if (press_count_reg == '0) begin
                    press_start_next = in_data_reg.time_ms;
                    last_press_next  = in_data_reg.time_ms;
                    count_tmp        = COUNT_W'(1);
                end else if (press_count_reg == COUNT_W'(1) && within_window) begin
                    out_data_next.hard_reset_request = 1'b1;
                    count_tmp = '0;
                end else begin
                    count_tmp = press_count_reg + COUNT_W'(1);
                end
            end else begin
                if (since_start >= {{(TIME_W-CFG_W){1'b0}}, long_reg}) begin
                    out_data_next.soft_reset_request = 1'b1;
                    count_tmp = '0;
                end else if (press_count_reg == COUNT_W'(1) && !within_window) begin
                    count_tmp = '0;
                end
            end
            press_count_next = (count_tmp > COUNT_LIMIT) ? '0 : count_tmp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            last_accepted_reg <= '0;
            press_start_reg   <= '0;
            last_press_reg    <= '0;
            press_count_reg   <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg     <= 1'b1;
                last_accepted_reg <= last_accepted_next;
                press_start_reg   <= press_start_next;
                last_press_reg    <= last_press_next;
                press_count_reg   <= press_count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

`include "button_long_double_press_detector_top_assert.svh"

    `BLDPD_ASSERT(a_count_in_range, press_count_reg <= COUNT_LIMIT, "press count passed limit")
    `BLDPD_ASSERT(a_not_both, !(m_valid && (&m_data)), "hard and soft request together")
    `BLDPD_ASSERT_IMPL(a_step_fills_out, $past(step), out_valid_reg, "evaluated item lost")
    `BLDPD_ASSERT_IMPL(a_soft_clears_count, $past(step) && m_data.soft_reset_request,
                       press_count_reg == '0, "soft request left count set")
    `BLDPD_ASSERT_IMPL(a_ready_when_empty, !out_valid_reg, s_ready, "input stalled with empty output")

endmodule
